// ===== sv/vrt_pkg.sv =====
`timescale 1ns / 1ps
package vrt_pkg;

  localparam int CHUNK_EDGE   = 16;
  localparam int WORLD_EDGE   = 64;
  localparam int WORLD_HEIGHT = 64;
  localparam int FRAC_BITS    = 16;

  localparam int CHUNKS_PER_AXIS = WORLD_EDGE / CHUNK_EDGE;
  localparam int XZ_W    = $clog2(WORLD_EDGE);
  localparam int Y_W     = $clog2(WORLD_HEIGHT);
  localparam int LOC_W   = $clog2(CHUNK_EDGE);
  localparam int ADDR_W  = 2 * XZ_W + Y_W;
  localparam int DEPTH   = WORLD_EDGE * WORLD_EDGE * WORLD_HEIGHT;

  // divider: numerator up to 2^(2F), divisor up to 2^(DIR_W-1)
  localparam int DIR_W   = 18;
  localparam int ORG_W   = 28;
  localparam int AORG_W  = ORG_W + 1;
  localparam int MAG_W   = DIR_W;
  localparam int NUM_W   = 2 * FRAC_BITS + 1;
  localparam int CELL_W  = AORG_W - FRAC_BITS + 1;
  localparam int T_W     = NUM_W + 7;

  localparam logic OP_WRITE      = 1'b0;
  localparam logic OP_RAY        = 1'b1;
  localparam logic REG_VOFFSET   = 1'b0;
  localparam logic REG_MAX_STEPS = 1'b1;

  localparam logic [2:0] FACE_PX = 3'd0;
  localparam logic [2:0] FACE_NX = 3'd1;
  localparam logic [2:0] FACE_PY = 3'd2;
  localparam logic [2:0] FACE_NY = 3'd3;
  localparam logic [2:0] FACE_PZ = 3'd4;
  localparam logic [2:0] FACE_NZ = 3'd5;

  typedef struct packed {
    logic              wr;
    logic [ADDR_W-1:0] waddr;
    logic              wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

// ===== sv/vrt_div.sv =====
`timescale 1ns / 1ps
module vrt_div import vrt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [MAG_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [MAG_W-1:0] rem;
  logic [MAG_W:0]   trial;
  logic [MAG_W-1:0] den_q;

  assign busy  = (cnt != '0);
  assign trial = {rem, quot[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        cnt <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) done <= 1'b1;
      end
    end
  end

  // one quotient bit a cycle, restoring
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      quot  <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      if (trial >= {1'b0, den_q}) begin
        rem  <= MAG_W'(trial - {1'b0, den_q});
        quot <= {quot[NUM_W-2:0], 1'b1};
      end else begin
        rem  <= trial[MAG_W-1:0];
        quot <= {quot[NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== sv/vrt_store.sv =====
`timescale 1ns / 1ps
module vrt_store import vrt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mem_req_t req,
  output logic     rdata,
  output logic     clearing
);

  logic              mem [0:DEPTH-1];
  logic [ADDR_W:0]   clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      clearing <= 1'b1;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == (ADDR_W+1)'(DEPTH - 1)) clearing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt[ADDR_W-1:0]] <= 1'b0;
    end else if (req.wr) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ===== sv/voxel_ray_traversal_top.sv =====
`timescale 1ns / 1ps
// Channel   | Direction | Beat fields
// s_axis    | in        | tuser: operation; tdata: write/ray fields
// m_axis    | out       | tdata: hit .. entry_face, one beat per ray
// cfg       | in        | cfg_index selects register, cfg_data value
// A voxel write is taken in the idle state. A ray runs up to six divisions,
// two per axis, on the one shared divider (none for an axis with zero
// direction), then walk steps (store read, then compare and step), then ends
// the walk and loads the result.
// After reset the store clears one voxel a cycle, all 262144 of them; s_tready
// stays low meanwhile. A finished ray holds until the output register drains.
module voxel_ray_traversal_top import vrt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata: write_x[5:0] write_y[11:6] write_z[17:12] write_value[18]
  //        origin_x[46:19] origin_y[74:47] origin_z[102:75]
  //        dir_x[120:103] dir_y[138:121] dir_z[156:139], zero fill
  input  logic [159:0] s_tdata,
  // tuser: operation[0]
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata: hit[0] chunk_index[4:1] local_x[8:5] hit_y[14:9] local_z[18:15]
  //        entry_face[21:19], zero fill
  output logic [23:0]  m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [20:0]  cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DSET  = 3'd1;
  localparam logic [2:0] ST_DWAIT = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_CHK   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam logic [T_W-1:0] T_SAT = '1;

  logic [2:0] state;
  logic [20:0] voff;
  logic [6:0]  max_steps;

  logic signed [AORG_W-1:0] org [0:2];
  logic signed [DIR_W-1:0]  dir [0:2];
  logic signed [CELL_W-1:0] p   [0:2];
  logic [T_W-1:0]           t   [0:2];
  logic [T_W-1:0]           dt  [0:2];
  logic [2:0]               mv;
  logic [2:0]               neg;
  logic [1:0]               k;
  logic                     sub;
  logic [6:0]               step_cnt;
  logic [2:0]               face;
  logic                     tested;

  mem_req_t req;
  logic     rdata, clearing;

  logic             div_start, div_busy, div_done;
  logic [NUM_W-1:0] div_num, div_quot;
  logic [MAG_W-1:0] mag_k;
  logic signed [AORG_W-1:0] org_k;
  logic signed [DIR_W-1:0]  dir_k;
  logic [FRAC_BITS:0]       dist_k;
  logic [2:0]               c;
  logic                     in_world;
  logic [23:0]              res;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE) && !clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      voff      <= 21'd65536;
      max_steps <= 7'd16;
    end else if (cfg_valid) begin
      if (cfg_index == REG_VOFFSET) voff <= cfg_data;
      if (cfg_index == REG_MAX_STEPS) max_steps <= cfg_data[6:0];
    end
  end

  // axis under setup
  always_comb begin
    case (k)
      2'd0:    begin org_k = org[0]; dir_k = dir[0]; end
      2'd1:    begin org_k = org[1]; dir_k = dir[1]; end
      default: begin org_k = org[2]; dir_k = dir[2]; end
    endcase
    mag_k  = dir_k[DIR_W-1] ? MAG_W'(-dir_k) : MAG_W'(dir_k);
    dist_k = dir_k[DIR_W-1] ? {1'b0, org_k[FRAC_BITS-1:0]}
                            : (FRAC_BITS+1)'((FRAC_BITS+1)'(1) << FRAC_BITS)
                              - {1'b0, org_k[FRAC_BITS-1:0]};
    div_num = sub ? NUM_W'({dist_k, {FRAC_BITS{1'b0}}})
                  : NUM_W'(NUM_W'(1) << (2 * FRAC_BITS));
  end

  assign div_start = (state == ST_DSET) && (dir_k != '0);

  vrt_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(mag_k),
    .busy(div_busy), .done(div_done), .quot(div_quot)
  );

  // step choice: every axis tied for least t steps; face picks x before y before z
  always_comb begin
    c[0] = mv[0] && t[0] <= t[1] && t[0] <= t[2];
    c[1] = mv[1] && t[1] <= t[0] && t[1] <= t[2];
    c[2] = mv[2] && t[2] <= t[1] && t[2] <= t[0];
    in_world = (p[0] >= 0) && (p[0] < CELL_W'(WORLD_EDGE)) &&
               (p[2] >= 0) && (p[2] < CELL_W'(WORLD_EDGE)) &&
               (p[1] >= 0) && (p[1] < CELL_W'(WORLD_HEIGHT));
  end

  always_comb begin
    req.wr    = (state == ST_IDLE) && s_tvalid && s_tready && (s_tuser == OP_WRITE);
    req.waddr = {s_tdata[5:0], s_tdata[11:6], s_tdata[17:12]};
    req.wdata = s_tdata[18];
    req.raddr = {p[0][XZ_W-1:0], p[1][Y_W-1:0], p[2][XZ_W-1:0]};
  end

  vrt_store u_store (
    .clk(clk), .rst(rst), .req(req), .rdata(rdata), .clearing(clearing)
  );

  always_comb begin
    res = '0;
    res[0]     = 1'b1;
    res[4:1]   = 4'(p[0][XZ_W-1:LOC_W] * CHUNKS_PER_AXIS + p[2][XZ_W-1:LOC_W]);
    res[8:5]   = 4'(p[0][LOC_W-1:0]);
    res[14:9]  = 6'(p[1][Y_W-1:0]);
    res[18:15] = 4'(p[2][LOC_W-1:0]);
    res[21:19] = face;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_DONE && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready && s_tuser != OP_WRITE) state <= ST_DSET;
        end
        ST_DSET: begin
          if (dir_k != '0) state <= ST_DWAIT;
          else if (k == 2'd2) state <= ST_RD;
        end
        ST_DWAIT: begin
          if (div_done) begin
            if (sub && k == 2'd2) state <= ST_RD;
            else state <= ST_DSET;
          end
        end
        ST_RD: begin
          if (step_cnt >= max_steps || p[1] < 0) state <= ST_DONE;
          else state <= ST_CHK;
        end
        ST_CHK: begin
          if (tested && rdata) state <= ST_DONE;
          else state <= ST_RD;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        org[0] <= AORG_W'($signed(s_tdata[46:19]));
        org[1] <= AORG_W'($signed(s_tdata[74:47])) - $signed({8'd0, voff});
        org[2] <= AORG_W'($signed(s_tdata[102:75]));
        dir[0] <= $signed(s_tdata[120:103]);
        dir[1] <= $signed(s_tdata[138:121]);
        dir[2] <= $signed(s_tdata[156:139]);
        p[0]   <= CELL_W'($signed(s_tdata[46:19]) >>> FRAC_BITS);
        p[1]   <= CELL_W'((AORG_W'($signed(s_tdata[74:47])) - $signed({8'd0, voff}))
                  >>> FRAC_BITS);
        p[2]   <= CELL_W'($signed(s_tdata[102:75]) >>> FRAC_BITS);
        k        <= 2'd0;
        sub      <= 1'b0;
        step_cnt <= '0;
        face     <= FACE_PX;
        tested   <= 1'b0;
      end
      ST_DSET: begin
        neg[k] <= dir_k[DIR_W-1];
        if (dir_k == '0) begin
          t[k]  <= T_SAT;
          dt[k] <= '0;
          mv[k] <= 1'b0;
          k     <= k + 1'b1;
        end else begin
          mv[k] <= 1'b1;
        end
      end
      ST_DWAIT: begin
        if (div_done) begin
          if (sub) begin
            t[k] <= T_W'(div_quot);
            k    <= k + 1'b1;
          end else begin
            dt[k] <= T_W'(div_quot);
          end
          sub <= !sub;
        end
      end
      ST_RD: begin
        tested <= (step_cnt != '0) && in_world;
      end
      ST_CHK: begin
        if (!(tested && rdata)) begin
          if (c[0])      face <= neg[0] ? FACE_PX : FACE_NX;
          else if (c[1]) face <= neg[1] ? FACE_PY : FACE_NY;
          else if (c[2]) face <= neg[2] ? FACE_PZ : FACE_NZ;
          for (int j = 0; j < 3; j++) begin
            if (c[j]) begin
              t[j] <= t[j] + dt[j];
              p[j] <= neg[j] ? p[j] - 1'b1 : p[j] + 1'b1;
            end
          end
          step_cnt <= step_cnt + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // load result: hit record or all zeros
  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= (tested && rdata && step_cnt < max_steps) ? res : '0;
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == ST_IDLE)
    else $error("input taken outside idle");

  a_nohit_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[23:1] == '0)
    else $error("miss result carries nonzero fields");

  a_steps: assert property (@(posedge clk) disable iff (rst)
    state == ST_CHK |-> step_cnt < max_steps)
    else $error("walk ran past step limit");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

endmodule
